>>> hw/rtl/pfdd_pkg.sv
package pfdd_pkg;

   localparam int SqDim       = 5;
   localparam int SqCells     = SqDim * SqDim;
   localparam int IdxWidth    = $clog2(SqDim);
   localparam int LetterWidth = 5;
   localparam int LetterI     = 8;
   localparam int LetterJ     = 9;
   localparam int LetterMax   = 25;
   localparam int CsrDataWidth = 60;
   localparam int CsrIdxWidth  = 2;
   localparam int CellsPerReg  = 12;

   typedef logic [LetterWidth-1:0] letter_type;
   typedef logic [IdxWidth-1:0]    idx_type;
   typedef logic [CsrIdxWidth-1:0] csr_idx_type;
   typedef logic [CsrDataWidth-1:0] csr_data_type;

   typedef letter_type [SqDim-1:0] row_type;
   typedef row_type    [SqDim-1:0] square_type;

   localparam csr_idx_type CsrCellsLow = 2'd0;
   localparam csr_idx_type CsrCellsMid = 2'd1;
   localparam csr_idx_type CsrCellLast = 2'd2;

   typedef struct packed {
      logic    hit_a;
      idx_type col_a;
      logic    hit_b;
      idx_type col_b;
   } lane_hit_type;

   typedef lane_hit_type [SqDim-1:0] lane_hits_type;

   // step back one place with wrap (left / up)
   function automatic idx_type wrap_dec(input idx_type v);
      idx_type r;
      if (v == '0) begin
         r = idx_type'(SqDim - 1);
      end else begin
         r = v - 1'b1;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/pfdd_if.sv
interface pfdd_req_if import pfdd_pkg::*; ();
   logic       valid;
   logic       ready;
   letter_type first_letter;
   letter_type second_letter;

   modport source(output valid, output first_letter, output second_letter, input ready);
   modport sink(input valid, input first_letter, input second_letter, output ready);
endinterface

interface pfdd_rsp_if import pfdd_pkg::*; ();
   logic       valid;
   logic       ready;
   letter_type first_plain;
   letter_type second_plain;
   logic       letter_missing;

   modport source(output valid, output first_plain, output second_plain,
                  output letter_missing, input ready);
   modport sink(input valid, input first_plain, input second_plain,
                input letter_missing, output ready);
endinterface

interface pfdd_csr_if import pfdd_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/pfdd_row_lane.sv
module pfdd_row_lane import pfdd_pkg::*; (
   input  row_type      row_cells,
   input  letter_type   letter_a,
   input  letter_type   letter_b,
   input  logic         usable_a,
   input  logic         usable_b,
   output lane_hit_type hit
);

   // lowest matching column wins
   always_comb begin
      hit = '0;
      for (int c = SqDim - 1; c >= 0; c--) begin
         if (usable_a && row_cells[c] == letter_a) begin
            hit.hit_a = 1'b1;
            hit.col_a = idx_type'(c);
         end
         if (usable_b && row_cells[c] == letter_b) begin
            hit.hit_b = 1'b1;
            hit.col_b = idx_type'(c);
         end
      end
   end

endmodule

>>> hw/rtl/pfdd_merge.sv
module pfdd_merge import pfdd_pkg::*; (
   input  lane_hits_type hits,
   input  square_type    square,
   output letter_type    first_plain,
   output letter_type    second_plain,
   output logic          letter_missing
);

   logic    found_a;
   logic    found_b;
   idx_type r1;
   idx_type c1;
   idx_type r2;
   idx_type c2;

   // lowest matching row wins
   always_comb begin
      found_a = 1'b0;
      found_b = 1'b0;
      r1 = '0;
      c1 = '0;
      r2 = '0;
      c2 = '0;
      for (int r = SqDim - 1; r >= 0; r--) begin
         if (hits[r].hit_a) begin
            found_a = 1'b1;
            r1 = idx_type'(r);
            c1 = hits[r].col_a;
         end
         if (hits[r].hit_b) begin
            found_b = 1'b1;
            r2 = idx_type'(r);
            c2 = hits[r].col_b;
         end
      end
   end

   always_comb begin
      letter_missing = !(found_a && found_b);
      if (letter_missing) begin
         first_plain  = '0;
         second_plain = '0;
      end else if (r1 == r2) begin
         first_plain  = square[r1][wrap_dec(c1)];
         second_plain = square[r2][wrap_dec(c2)];
      end else if (c1 == c2) begin
         first_plain  = square[wrap_dec(r1)][c1];
         second_plain = square[wrap_dec(r2)][c2];
      end else begin
         first_plain  = square[r1][c2];
         second_plain = square[r2][c1];
      end
   end

endmodule

>>> hw/rtl/playfair_digraph_decrypt_top.sv
// channel   dir   signals                                        accepted when
// req_ch    in    first_letter, second_letter                    valid && ready
// rsp_ch    out   first_plain, second_plain, letter_missing      valid && ready
// csr_ch    in    index, data                                    valid && ready
//
// One request per cycle unless the response stalls; both stages are registered.
// Stage 1: five row lanes compare both letters against their row in parallel.
// Stage 2: merge picks the matching rows and selects the output cells.
// Synchronous reset clears the key square and both stage valid bits.
// A stalled response holds stage 2; stage 1 still fills behind it.
module playfair_digraph_decrypt_top import pfdd_pkg::*; (
   input logic         clock,
   input logic         reset,
   pfdd_req_if.sink    req_ch,
   pfdd_rsp_if.source  rsp_ch,
   pfdd_csr_if.sink    csr_ch
);

   csr_data_type  cells_low_ff;
   csr_data_type  cells_mid_ff;
   letter_type    cell_last_ff;
   square_type    square;

   letter_type    key_a;
   letter_type    key_b;
   logic          usable_a;
   logic          usable_b;
   lane_hits_type lane_hits;

   lane_hits_type s1_hits_ff;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic          s1_adv;
   logic          out_free;
   logic          req_take;
   logic [SqDim-1:0] s1_hits_a;

   letter_type    m_first;
   letter_type    m_second;
   logic          m_missing;

   letter_type    first_plain_ff;
   letter_type    second_plain_ff;
   logic          missing_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   // key square registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_low_ff <= '0;
         cells_mid_ff <= '0;
         cell_last_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CsrCellsLow: cells_low_ff <= csr_ch.data;
            CsrCellsMid: cells_mid_ff <= csr_ch.data;
            CsrCellLast: cell_last_ff <= csr_ch.data[LetterWidth-1:0];
            default: ;
         endcase
      end
   end

   for (genvar k = 0; k < SqCells; k++) begin : g_cell
      if (k < CellsPerReg) begin : g_low
         assign square[k / SqDim][k % SqDim] = cells_low_ff[LetterWidth*k +: LetterWidth];
      end else if (k < 2 * CellsPerReg) begin : g_mid
         assign square[k / SqDim][k % SqDim] =
            cells_mid_ff[LetterWidth*(k-CellsPerReg) +: LetterWidth];
      end else begin : g_last
         assign square[k / SqDim][k % SqDim] = cell_last_ff;
      end
   end

   // J looks up as I; codes above Z never match
   assign key_a    = (req_ch.first_letter == letter_type'(LetterJ)) ?
                     letter_type'(LetterI) : req_ch.first_letter;
   assign key_b    = (req_ch.second_letter == letter_type'(LetterJ)) ?
                     letter_type'(LetterI) : req_ch.second_letter;
   assign usable_a = (key_a <= letter_type'(LetterMax));
   assign usable_b = (key_b <= letter_type'(LetterMax));

   for (genvar r = 0; r < SqDim; r++) begin : g_lane
      pfdd_row_lane u_lane (
         .row_cells (square[r]),
         .letter_a  (key_a),
         .letter_b  (key_b),
         .usable_a  (usable_a),
         .usable_b  (usable_b),
         .hit       (lane_hits[r])
      );
      assign s1_hits_a[r] = s1_hits_ff[r].hit_a;
   end

   // pipeline flow
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_hits_ff <= lane_hits;
      end
   end

   pfdd_merge u_merge (
      .hits           (s1_hits_ff),
      .square         (square),
      .first_plain    (m_first),
      .second_plain   (m_second),
      .letter_missing (m_missing)
   );

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         first_plain_ff  <= m_first;
         second_plain_ff <= m_second;
         missing_ff      <= m_missing;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.first_plain    = first_plain_ff;
   assign rsp_ch.second_plain   = second_plain_ff;
   assign rsp_ch.letter_missing = missing_ff;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff)
      else $error("stage 1 request dropped while stalled");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && missing_ff |-> first_plain_ff == '0 && second_plain_ff == '0)
      else $error("missing letter with non-zero plaintext");

   a_bad_code: assert property (@(posedge clock) disable iff (reset)
      req_take && req_ch.first_letter > letter_type'(LetterMax) |=> s1_hits_a == '0)
      else $error("letter code above Z matched a cell");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("request refused with empty output stage");

endmodule
